// ===== hdl/plsf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plsf_pkg
// Shared widths, constants and Q32.32 helpers for the least-squares fitter.
// ----------------------------------------------------------------------------
package plsf_pkg;

	localparam int XY_W           = 16;   // Q1.15 sample fields
	localparam int COEF_W         = 64;   // Q32.32 words
	localparam int DEG_W          = 3;
	localparam int IDX_W          = 3;
	localparam int MAX_DEGREE_DEF = 7;

	localparam logic [COEF_W-1:0] ONE_Q32    = 64'h0000_0001_0000_0000;
	localparam logic [COEF_W-1:0] Q_MIN      = 64'h8000_0000_0000_0000;
	localparam logic [COEF_W-1:0] Q_MAX      = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [DEG_W-1:0]  DEG_RESET  = 3'd1;

	// magnitude of a two's complement word, as unsigned
	function automatic logic [COEF_W-1:0] mag(input logic [COEF_W-1:0] v);
		mag = v[COEF_W-1] ? (COEF_W'(0) - v) : v;
	endfunction

	// signed saturation of a magnitude with excess high bits
	function automatic logic [COEF_W-1:0] sat_from(input logic neg, input logic hi_nz,
		input logic [COEF_W-1:0] lo);
		if (neg) begin
			if (hi_nz || (lo > Q_MIN)) sat_from = Q_MIN;
			else sat_from = COEF_W'(0) - lo;
		end else begin
			if (hi_nz || lo[COEF_W-1]) sat_from = Q_MAX;
			else sat_from = lo;
		end
	endfunction

endpackage

// ===== hdl/plsf_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plsf_if
// Valid/ready channels: sample points in, fitted coefficients out.
// ----------------------------------------------------------------------------
interface plsf_point_if;
	logic                                valid;
	logic                                ready;
	logic signed [plsf_pkg::XY_W-1:0]    x_value;
	logic signed [plsf_pkg::XY_W-1:0]    y_value;
	logic                                last_point;

	modport source(output valid, x_value, y_value, last_point, input ready);
	modport sink(input valid, x_value, y_value, last_point, output ready);
endinterface

interface plsf_coef_if;
	logic                                valid;
	logic                                ready;
	logic signed [plsf_pkg::COEF_W-1:0]  coefficient;
	logic [plsf_pkg::IDX_W-1:0]          coeff_index;
	logic                                last_coeff;
	logic                                singular;
	logic                                sum_overflow;

	modport source(output valid, coefficient, coeff_index, last_coeff, singular,
		sum_overflow, input ready);
	modport sink(input valid, coefficient, coeff_index, last_coeff, singular,
		sum_overflow, output ready);
endinterface

// ===== hdl/plsf_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plsf_mul
// Q32.32 multiply with rounding and saturation, one 32x32 partial a cycle.
// ----------------------------------------------------------------------------
module plsf_mul (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [plsf_pkg::COEF_W-1:0]   a,
	input  logic [plsf_pkg::COEF_W-1:0]   b,
	output logic                          done,
	output logic [plsf_pkg::COEF_W-1:0]   res
);
	import plsf_pkg::*;

	localparam int HW = COEF_W / 2;
	localparam int PW = 2 * COEF_W;

	logic              busy_q, done_q;
	logic [2:0]        cnt_q;
	logic [COEF_W-1:0] ma_q, mb_q, res_q;
	logic              neg_q;
	logic [PW-1:0]     acc_q;
	logic [COEF_W-1:0] pp;
	logic [PW-1:0]     pp_sh;
	logic [PW-1:0]     rnd;

	always_comb begin
		pp    = '0;
		pp_sh = '0;
		case (cnt_q)
			3'd0: begin
				pp    = ma_q[HW-1:0] * mb_q[HW-1:0];
				pp_sh = PW'(pp);
			end
			3'd1: begin
				pp    = ma_q[HW-1:0] * mb_q[COEF_W-1:HW];
				pp_sh = PW'(pp) << HW;
			end
			3'd2: begin
				pp    = ma_q[COEF_W-1:HW] * mb_q[HW-1:0];
				pp_sh = PW'(pp) << HW;
			end
			3'd3: begin
				pp    = ma_q[COEF_W-1:HW] * mb_q[COEF_W-1:HW];
				pp_sh = PW'(pp) << COEF_W;
			end
			default: begin
				pp    = '0;
				pp_sh = '0;
			end
		endcase
		// round half up: bias differs by sign so a tie rounds towards plus infinity
		rnd = acc_q + (neg_q ? PW'(32'h7FFF_FFFF) : PW'(32'h8000_0000));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == 3'd4) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 3'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			ma_q  <= mag(a);
			mb_q  <= mag(b);
			neg_q <= a[COEF_W-1] ^ b[COEF_W-1];
			acc_q <= '0;
		end else if (busy_q) begin
			if (cnt_q == 3'd4)
				res_q <= sat_from(neg_q, |rnd[PW-1:PW-HW], rnd[PW-HW-1:HW]);
			else
				acc_q <= acc_q + pp_sh;
		end
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

// ===== hdl/plsf_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plsf_div
// Q32.32 divide, restoring, one quotient bit a cycle; divide by zero gives 0.
// ----------------------------------------------------------------------------
module plsf_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [plsf_pkg::COEF_W-1:0]   a,
	input  logic [plsf_pkg::COEF_W-1:0]   b,
	output logic                          done,
	output logic [plsf_pkg::COEF_W-1:0]   res
);
	import plsf_pkg::*;

	localparam int FW    = COEF_W / 2;      // fraction bits
	localparam int NW    = COEF_W + FW;     // numerator bits
	localparam int CNT_W = $clog2(NW);

	logic              busy_q, done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [NW-1:0]     num_q, q_q, q_nx;
	logic [COEF_W-1:0] dv_q, r_q, r_nx, res_q;
	logic              neg_q, zero_q;
	logic [COEF_W:0]   rx;
	logic              qbit;

	always_comb begin
		rx   = {r_q, num_q[NW-1]};
		qbit = (rx >= {1'b0, dv_q});
		r_nx = qbit ? COEF_W'(rx - {1'b0, dv_q}) : rx[COEF_W-1:0];
		q_nx = {q_q[NW-2:0], qbit};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CNT_W'(NW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q  <= {mag(a), FW'(0)};
			dv_q   <= mag(b);
			r_q    <= '0;
			q_q    <= '0;
			neg_q  <= a[COEF_W-1] ^ b[COEF_W-1];
			zero_q <= (b == '0);
		end else if (busy_q) begin
			num_q <= num_q << 1;
			r_q   <= r_nx;
			q_q   <= q_nx;
			if (cnt_q == CNT_W'(NW - 1))
				res_q <= zero_q ? '0 : sat_from(neg_q, |q_nx[NW-1:COEF_W], q_nx[COEF_W-1:0]);
		end
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

// ===== hdl/polynomial_least_squares_fit.sv =====
`timescale 1ns / 1ps
// A point steps the one shared 34x16 power multiplier through every power term,
//   in the states LY, LX and LP.
// The last point adds a solve of about n^3/3 multiplies and n^2/2 divides; a divide makes
//   one quotient bit a cycle.
// Throughput: one point at a time; point.ready is high only while idle.
// Reset clears sums and overflow flag, sets deg_q to 1; the solve RAM is not cleared.
// ----------------------------------------------------------------------------
// polynomial_least_squares_fit
// Polynomial least-squares fit: power-sum accumulation, LU solve with partial
// pivoting, coefficients emitted highest power first.
// ----------------------------------------------------------------------------
module polynomial_least_squares_fit #(
	parameter int MAX_DEGREE = plsf_pkg::MAX_DEGREE_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [plsf_pkg::DEG_W-1:0]    cfg_wdata,
	plsf_point_if.sink                    point,
	plsf_coef_if.source                   coef
);
	import plsf_pkg::*;

	// --- sizes -------------------------------------------------------------
	localparam int NDIM  = MAX_DEGREE + 1;       // matrix rows
	localparam int NCOL  = MAX_DEGREE + 2;       // rows carry the RHS in one extra column
	localparam int NPOW  = 2 * MAX_DEGREE + 1;   // power sums
	localparam int DEPTH = NDIM * NCOL;
	localparam int AW    = $clog2(DEPTH);
	localparam int PW    = $clog2(NPOW);
	localparam int RW    = $clog2(NDIM);
	localparam int CLW   = $clog2(NCOL);
	localparam int PB    = 34;                   // running power, |p| <= 1.0 in Q32.32
	localparam int MB    = PB + XY_W;            // power times sample

	// --- sequencer codes ---------------------------------------------------
	localparam logic [5:0] ST_IDLE    = 6'd0;
	localparam logic [5:0] ST_LY      = 6'd1;   // p*y, power sum
	localparam logic [5:0] ST_LX      = 6'd2;   // cross sum, p*x
	localparam logic [5:0] ST_LP      = 6'd3;   // next power
	localparam logic [5:0] ST_BLD     = 6'd4;   // fill normal equations
	localparam logic [5:0] ST_EL      = 6'd5;   // next elimination column
	localparam logic [5:0] ST_PV_RD   = 6'd6;
	localparam logic [5:0] ST_PV_CMP  = 6'd7;
	localparam logic [5:0] ST_SW_RA   = 6'd8;
	localparam logic [5:0] ST_SW_RB   = 6'd9;
	localparam logic [5:0] ST_SW_WA   = 6'd10;
	localparam logic [5:0] ST_SW_WB   = 6'd11;
	localparam logic [5:0] ST_PIV_RD  = 6'd12;
	localparam logic [5:0] ST_PIV_GET = 6'd13;
	localparam logic [5:0] ST_L_RD    = 6'd14;
	localparam logic [5:0] ST_L_DIV   = 6'd15;
	localparam logic [5:0] ST_L_WAIT  = 6'd16;
	localparam logic [5:0] ST_U_RDI   = 6'd17;
	localparam logic [5:0] ST_U_RDJ   = 6'd18;
	localparam logic [5:0] ST_U_MUL   = 6'd19;
	localparam logic [5:0] ST_U_WAIT  = 6'd20;
	localparam logic [5:0] ST_R_RDV   = 6'd21;
	localparam logic [5:0] ST_R_GETV  = 6'd22;
	localparam logic [5:0] ST_R_RDM   = 6'd23;
	localparam logic [5:0] ST_R_RDX   = 6'd24;
	localparam logic [5:0] ST_R_MUL   = 6'd25;
	localparam logic [5:0] ST_R_WAIT  = 6'd26;
	localparam logic [5:0] ST_R_DRD   = 6'd27;
	localparam logic [5:0] ST_R_DDIV  = 6'd28;
	localparam logic [5:0] ST_R_DWAIT = 6'd29;
	localparam logic [5:0] ST_R_WR    = 6'd30;
	localparam logic [5:0] ST_EM_RD   = 6'd31;
	localparam logic [5:0] ST_EM_GET  = 6'd32;
	localparam logic [5:0] ST_EM_OUT  = 6'd33;

	// --- saturating add/sub on Q32.32; the add also returns the overflow bit
	function automatic logic [COEF_W:0] sat_add(input logic [COEF_W-1:0] a,
		input logic [COEF_W-1:0] b);
		logic [COEF_W-1:0] s;
		s = a + b;
		if ((a[COEF_W-1] == b[COEF_W-1]) && (s[COEF_W-1] != a[COEF_W-1]))
			sat_add = {1'b1, a[COEF_W-1] ? Q_MIN : Q_MAX};
		else
			sat_add = {1'b0, s};
	endfunction

	function automatic logic [COEF_W-1:0] sat_sub(input logic [COEF_W-1:0] a,
		input logic [COEF_W-1:0] b);
		logic [COEF_W-1:0] s;
		s = a - b;
		if ((a[COEF_W-1] != b[COEF_W-1]) && (s[COEF_W-1] != a[COEF_W-1]))
			sat_sub = a[COEF_W-1] ? Q_MIN : Q_MAX;
		else
			sat_sub = s;
	endfunction

	// --- state -------------------------------------------------------------
	logic [5:0]        st_q;
	logic [DEG_W-1:0]  deg_q;
	logic [PW-1:0]     k_q;
	logic [RW-1:0]     d_q, i_q, j_q, best_q;
	logic [CLW-1:0]    c_q;
	logic              bk_q;          // back substitution pass
	logic              sing_q, ovf_q;
	logic [COEF_W-1:0] pw_q [NPOW];   // sum x^k
	logic [COEF_W-1:0] cx_q [NDIM];   // sum x^k*y

	logic signed [XY_W-1:0] x_q, y_q;
	logic              last_q;
	logic signed [PB-1:0]   p_q;
	logic signed [MB-1:0]   prod_q;
	logic [COEF_W-1:0] bm_q, t1_q, piv_q, l_q, tmp_q, acc_q, opa_q, coef_q;

	// solve RAM: row-major, NCOL words a row, last used column holds the RHS
	logic [COEF_W-1:0] mem [DEPTH];
	logic [COEF_W-1:0] rd_q;

	// --- combinational -----------------------------------------------------
	logic signed [XY_W-1:0] mul_b;
	logic signed [MB-1:0]   mprod, rsum;
	logic [COEF_W-1:0] p_ext, pw_rd, cx_rd;
	logic [COEF_W:0]   pw_add, cx_add;
	logic [PW-1:0]     pw_ra;
	logic [RW-1:0]     cx_ra;
	logic              k_in_cx;
	logic [RW-1:0]     d_sat;
	logic [CLW-1:0]    cn;            // RHS column = n = d+1
	logic [COEF_W-1:0] m_cur, nbm;
	logic [RW-1:0]     nbest;
	logic [RW-1:0]     ra_row, wa_row;
	logic [CLW-1:0]    ra_col, wa_col;
	logic [AW-1:0]     raddr, waddr;
	logic              we;
	logic [COEF_W-1:0] wdata;
	logic              mul_go, div_go, mul_done, div_done;
	logic [COEF_W-1:0] mul_a, mul_bq, div_a, div_b, mul_res, div_res;

	// power chain: the one small multiplier takes p*y, then p*x
	assign mul_b  = (st_q == ST_LY) ? y_q : x_q;
	assign mprod  = p_q * mul_b;
	assign rsum   = prod_q + MB'(16384);          // round, then floor >> 15
	assign p_ext  = {{(COEF_W-PB){p_q[PB-1]}}, p_q};
	assign k_in_cx = (32'(k_q) < NDIM);

	assign d_sat = (32'(deg_q) > MAX_DEGREE) ? RW'(MAX_DEGREE) : RW'(deg_q);
	assign cn    = CLW'(d_q) + CLW'(1);

	// sum read ports: load walks k, build reads S[2d-i-c] and T[d-i]
	assign pw_ra  = (st_q == ST_BLD) ?
		PW'(2 * int'(d_q) - int'(i_q) - int'(c_q)) : k_q;
	assign cx_ra  = (st_q == ST_BLD) ? RW'(d_q - i_q) : k_q[RW-1:0];
	assign pw_rd  = pw_q[pw_ra];
	assign cx_rd  = cx_q[cx_ra];
	assign pw_add = sat_add(pw_rd, p_ext);
	assign cx_add = sat_add(cx_rd, {{(COEF_W-(MB-15)){rsum[MB-1]}}, rsum[MB-1:15]});

	// pivot search: largest magnitude, first row on a tie
	always_comb begin
		m_cur = mag(rd_q);
		nbm   = bm_q;
		nbest = best_q;
		if (j_q == i_q) begin
			nbm   = m_cur;
			nbest = i_q;
		end else if (bm_q < m_cur) begin
			nbm   = m_cur;
			nbest = j_q;
		end
	end

	// RAM address and write selection
	always_comb begin
		ra_row = i_q;
		ra_col = CLW'(i_q);
		wa_row = i_q;
		wa_col = c_q;
		we     = 1'b0;
		wdata  = acc_q;
		case (st_q)
			ST_PV_RD:  begin ra_row = j_q;    ra_col = CLW'(i_q); end
			ST_SW_RA:  begin ra_row = i_q;    ra_col = c_q;       end
			ST_SW_RB:  begin ra_row = best_q; ra_col = c_q;       end
			ST_PIV_RD: begin ra_row = i_q;    ra_col = CLW'(i_q); end
			ST_L_RD:   begin ra_row = j_q;    ra_col = CLW'(i_q); end
			ST_U_RDI:  begin ra_row = i_q;    ra_col = c_q;       end
			ST_U_RDJ:  begin ra_row = j_q;    ra_col = c_q;       end
			ST_R_RDV:  begin ra_row = i_q;    ra_col = cn;        end
			ST_R_RDM:  begin ra_row = i_q;    ra_col = CLW'(j_q); end
			ST_R_RDX:  begin ra_row = j_q;    ra_col = cn;        end
			ST_R_DRD:  begin ra_row = i_q;    ra_col = CLW'(i_q); end
			ST_EM_RD:  begin ra_row = i_q;    ra_col = cn;        end
			default:   begin ra_row = i_q;    ra_col = CLW'(i_q); end
		endcase
		case (st_q)
			ST_BLD: begin
				we    = 1'b1;
				wdata = (c_q == cn) ? cx_rd : pw_rd;
			end
			ST_SW_WA: begin
				we    = 1'b1;
				wdata = rd_q;
			end
			ST_SW_WB: begin
				we     = 1'b1;
				wa_row = best_q;
				wdata  = t1_q;
			end
			ST_L_WAIT: begin
				we     = div_done;
				wa_row = j_q;
				wa_col = CLW'(i_q);
				wdata  = div_res;
			end
			ST_U_WAIT: begin
				we     = mul_done;
				wa_row = j_q;
				wdata  = sat_sub(tmp_q, mul_res);
			end
			ST_R_WR: begin
				we     = 1'b1;
				wa_col = cn;
				wdata  = acc_q;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	assign raddr = AW'(int'(ra_row) * NCOL + int'(ra_col));
	assign waddr = AW'(int'(wa_row) * NCOL + int'(wa_col));

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rd_q <= mem[raddr];
	end

	// shared solve units
	assign mul_go = (st_q == ST_U_MUL) || (st_q == ST_R_MUL);
	assign mul_a  = (st_q == ST_U_MUL) ? l_q : opa_q;
	assign mul_bq = (st_q == ST_U_MUL) ? opa_q : rd_q;
	assign div_go = (st_q == ST_L_DIV) || (st_q == ST_R_DDIV);
	assign div_a  = (st_q == ST_L_DIV) ? rd_q : acc_q;
	assign div_b  = (st_q == ST_L_DIV) ? piv_q : rd_q;

	plsf_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_go),
		.a      (mul_a),
		.b      (mul_bq),
		.done   (mul_done),
		.res    (mul_res)
	);

	plsf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_go),
		.a      (div_a),
		.b      (div_b),
		.done   (div_done),
		.res    (div_res)
	);

	// --- sequencer ---------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_IDLE;
			deg_q  <= DEG_RESET;
			k_q    <= '0;
			d_q    <= '0;
			i_q    <= '0;
			j_q    <= '0;
			c_q    <= '0;
			bk_q   <= 1'b0;
			sing_q <= 1'b0;
			ovf_q  <= 1'b0;
			for (int n = 0; n < NPOW; n++) pw_q[n] <= '0;
			for (int n = 0; n < NDIM; n++) cx_q[n] <= '0;
		end else begin
			if (cfg_we)
				deg_q <= cfg_wdata;
			case (st_q)
				ST_IDLE: begin
					if (point.valid) begin
						k_q  <= '0;
						st_q <= ST_LY;
					end
				end
				ST_LY: begin
					pw_q[k_q] <= pw_add[COEF_W-1:0];
					if (pw_add[COEF_W]) ovf_q <= 1'b1;
					st_q <= ST_LX;
				end
				ST_LX: begin
					if (k_in_cx) begin
						cx_q[cx_ra] <= cx_add[COEF_W-1:0];
						if (cx_add[COEF_W]) ovf_q <= 1'b1;
					end
					st_q <= ST_LP;
				end
				ST_LP: begin
					if (k_q == PW'(NPOW - 1)) begin
						if (last_q) begin
							d_q    <= d_sat;
							i_q    <= '0;
							c_q    <= '0;
							sing_q <= 1'b0;
							st_q   <= ST_BLD;
						end else begin
							st_q <= ST_IDLE;
						end
					end else begin
						k_q  <= k_q + PW'(1);
						st_q <= ST_LY;
					end
				end
				ST_BLD: begin
					if (c_q == cn) begin
						c_q <= '0;
						if (i_q == d_q) begin
							i_q  <= '0;
							st_q <= ST_EL;
						end else begin
							i_q <= i_q + RW'(1);
						end
					end else begin
						c_q <= c_q + CLW'(1);
					end
				end
				ST_EL: begin
					if (i_q < d_q) begin
						j_q  <= i_q;
						st_q <= ST_PV_RD;
					end else if (d_q != '0) begin
						// forward pass starts at row 1
						bk_q <= 1'b0;
						i_q  <= RW'(1);
						st_q <= ST_R_RDV;
					end else begin
						bk_q <= 1'b1;
						i_q  <= d_q;
						st_q <= ST_R_RDV;
					end
				end
				ST_PV_RD: st_q <= ST_PV_CMP;
				ST_PV_CMP: begin
					if (j_q == d_q) begin
						c_q  <= '0;
						st_q <= (nbest != i_q) ? ST_SW_RA : ST_PIV_RD;
					end else begin
						j_q  <= j_q + RW'(1);
						st_q <= ST_PV_RD;
					end
				end
				ST_SW_RA: st_q <= ST_SW_RB;
				ST_SW_RB: st_q <= ST_SW_WA;
				ST_SW_WA: st_q <= ST_SW_WB;
				ST_SW_WB: begin
					if (c_q == cn) begin
						st_q <= ST_PIV_RD;
					end else begin
						c_q  <= c_q + CLW'(1);
						st_q <= ST_SW_RA;
					end
				end
				ST_PIV_RD: st_q <= ST_PIV_GET;
				ST_PIV_GET: begin
					if (rd_q == '0) sing_q <= 1'b1;
					j_q  <= i_q + RW'(1);
					st_q <= ST_L_RD;
				end
				ST_L_RD:  st_q <= ST_L_DIV;
				ST_L_DIV: st_q <= ST_L_WAIT;
				ST_L_WAIT: begin
					if (div_done) begin
						c_q  <= CLW'(i_q) + CLW'(1);
						st_q <= ST_U_RDI;
					end
				end
				ST_U_RDI: st_q <= ST_U_RDJ;
				ST_U_RDJ: st_q <= ST_U_MUL;
				ST_U_MUL: st_q <= ST_U_WAIT;
				ST_U_WAIT: begin
					if (mul_done) begin
						if (c_q == CLW'(d_q)) begin
							if (j_q == d_q) begin
								i_q  <= i_q + RW'(1);
								st_q <= ST_EL;
							end else begin
								j_q  <= j_q + RW'(1);
								st_q <= ST_L_RD;
							end
						end else begin
							c_q  <= c_q + CLW'(1);
							st_q <= ST_U_RDI;
						end
					end
				end
				ST_R_RDV: st_q <= ST_R_GETV;
				ST_R_GETV: begin
					if (bk_q) begin
						j_q  <= d_q;
						st_q <= (i_q == d_q) ? ST_R_DRD : ST_R_RDM;
					end else begin
						j_q  <= '0;
						st_q <= ST_R_RDM;
					end
				end
				ST_R_RDM: st_q <= ST_R_RDX;
				ST_R_RDX: st_q <= ST_R_MUL;
				ST_R_MUL: st_q <= ST_R_WAIT;
				ST_R_WAIT: begin
					if (mul_done) begin
						if (!bk_q) begin
							if ((j_q + RW'(1)) == i_q) begin
								st_q <= ST_R_WR;
							end else begin
								j_q  <= j_q + RW'(1);
								st_q <= ST_R_RDM;
							end
						end else begin
							if ((j_q - RW'(1)) == i_q) begin
								st_q <= ST_R_DRD;
							end else begin
								j_q  <= j_q - RW'(1);
								st_q <= ST_R_RDM;
							end
						end
					end
				end
				ST_R_DRD: st_q <= ST_R_DDIV;
				ST_R_DDIV: begin
					if (rd_q == '0) sing_q <= 1'b1;
					st_q <= ST_R_DWAIT;
				end
				ST_R_DWAIT: begin
					if (div_done) st_q <= ST_R_WR;
				end
				ST_R_WR: begin
					if (!bk_q) begin
						if (i_q == d_q) begin
							bk_q <= 1'b1;
						end else begin
							i_q <= i_q + RW'(1);
						end
						st_q <= ST_R_RDV;
					end else if (i_q == '0) begin
						st_q <= ST_EM_RD;
					end else begin
						i_q  <= i_q - RW'(1);
						st_q <= ST_R_RDV;
					end
				end
				ST_EM_RD:  st_q <= ST_EM_GET;
				ST_EM_GET: st_q <= ST_EM_OUT;
				ST_EM_OUT: begin
					if (coef.ready) begin
						if (i_q == d_q) begin
							// set done: clear the sums for the next data set
							for (int n = 0; n < NPOW; n++) pw_q[n] <= '0;
							for (int n = 0; n < NDIM; n++) cx_q[n] <= '0;
							ovf_q <= 1'b0;
							st_q  <= ST_IDLE;
						end else begin
							i_q  <= i_q + RW'(1);
							st_q <= ST_EM_RD;
						end
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// --- datapath registers (no reset) -------------------------------------
	always_ff @(posedge clk) begin
		case (st_q)
			ST_IDLE: begin
				if (point.valid) begin
					x_q    <= point.x_value;
					y_q    <= point.y_value;
					last_q <= point.last_point;
					p_q    <= PB'(ONE_Q32);
				end
			end
			ST_LY:      prod_q <= mprod;
			ST_LX:      prod_q <= mprod;
			ST_LP:      p_q    <= rsum[PB+14:15];
			ST_PV_CMP: begin
				bm_q   <= nbm;
				best_q <= nbest;
			end
			ST_SW_RB:   t1_q   <= rd_q;
			ST_PIV_GET: piv_q  <= rd_q;
			ST_L_WAIT: begin
				if (div_done) l_q <= div_res;
			end
			ST_U_RDJ:   opa_q  <= rd_q;
			ST_U_MUL:   tmp_q  <= rd_q;
			ST_R_GETV:  acc_q  <= rd_q;
			ST_R_RDX:   opa_q  <= rd_q;
			ST_R_WAIT: begin
				if (mul_done) acc_q <= sat_sub(acc_q, mul_res);
			end
			ST_R_DWAIT: begin
				if (div_done) acc_q <= div_res;
			end
			ST_EM_GET:  coef_q <= rd_q;
			default: begin
				coef_q <= coef_q;
			end
		endcase
	end

	// --- ports ---------------------------------------------------------------
	assign point.ready       = (st_q == ST_IDLE);
	assign coef.valid        = (st_q == ST_EM_OUT);
	assign coef.coefficient  = coef_q;
	assign coef.coeff_index  = IDX_W'(i_q);
	assign coef.last_coeff   = (i_q == d_q);
	assign coef.singular     = sing_q;
	assign coef.sum_overflow = ovf_q;

`ifndef SYNTHESIS
	// never take a point while a coefficient is on offer
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		point.ready |-> !coef.valid)
		else $error("point accepted during coefficient output");

	// emitted row never runs past the degree
	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		coef.valid |-> (i_q <= d_q))
		else $error("coefficient row beyond degree");

	// final coefficient transfer returns to idle with the sums cleared
	a_clear_after: assert property (@(posedge clk) disable iff (!arst_n)
		(coef.valid && coef.ready && coef.last_coeff) |=>
		(st_q == ST_IDLE) && !ovf_q && (pw_q[0] == '0))
		else $error("sums not cleared after the run");

	// the shared units are never started together
	a_one_unit: assert property (@(posedge clk) disable iff (!arst_n)
		!(mul_go && div_go))
		else $error("multiply and divide started together");
`endif

endmodule

// ===== verif/plsf_fit_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plsf_fit_checker
// Watches the point, coefficient and configuration ports of the fitter. It
// keeps its own copy of the power and cross sums and solves the normal
// equations in Q32.32. Each coefficient transfer is compared with the oldest
// predicted coefficient.
// ----------------------------------------------------------------------------
module plsf_fit_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [plsf_pkg::DEG_W-1:0] cfg_wdata,
	plsf_point_if                      pt,
	plsf_coef_if                       cf,
	output int                         errors,
	output int                         pending
);
	import plsf_pkg::*;

	localparam int NDIM = MAX_DEGREE_DEF + 1;
	localparam int NPOW = 2 * MAX_DEGREE_DEF + 1;
	localparam longint LMIN = longint'(Q_MIN);
	localparam longint LMAX = longint'(Q_MAX);

	typedef struct packed {
		logic [COEF_W-1:0] coefficient;
		logic [IDX_W-1:0]  coeff_index;
		logic              last_coeff;
		logic              singular;
		logic              sum_overflow;
	} coef_t;

	coef_t            coef_q[$];
	longint           psum[NPOW];
	longint           xsum[NDIM];
	bit               acc_ovf;
	logic [DEG_W-1:0] degree;
	longint           mat[NDIM][NDIM];
	longint           vec[NDIM];

	function automatic logic [63:0] umag(input longint v);
		return v < 0 ? 64'd0 - 64'(v) : 64'(v);
	endfunction

	function automatic longint clamp_q(input logic neg, input logic hi_nz,
		input logic [63:0] lo);
		if (neg)
			return (hi_nz || lo > 64'h8000_0000_0000_0000) ? LMIN : longint'(64'd0 - lo);
		return (hi_nz || lo[63]) ? LMAX : longint'(lo);
	endfunction

	function automatic longint acc_add(input longint a, input longint b, inout bit ovf);
		longint s;
		s = a + b;
		if ((a < 0) == (b < 0) && (s < 0) != (a < 0)) begin
			ovf = 1'b1;
			return a < 0 ? LMIN : LMAX;
		end
		return s;
	endfunction

	function automatic longint q_sub(input longint a, input longint b);
		longint s;
		s = a - b;
		if ((a < 0) != (b < 0) && (s < 0) != (a < 0))
			return a < 0 ? LMIN : LMAX;
		return s;
	endfunction

	// rounded product; negative results round half towards zero in magnitude
	function automatic longint q_mul(input longint a, input longint b);
		logic [127:0] m;
		logic         neg;
		neg = (a < 0) != (b < 0);
		m = {64'd0, umag(a)} * {64'd0, umag(b)};
		m = m + (neg ? 128'h7FFF_FFFF : 128'h8000_0000);
		m = m >> 32;
		return clamp_q(neg, m[127:64] != 0, m[63:0]);
	endfunction

	function automatic longint q_div(input longint a, input longint b);
		logic [127:0] q;
		if (b == 0)
			return 0;
		q = {32'd0, umag(a), 32'd0} / {64'd0, umag(b)};
		return clamp_q((a < 0) != (b < 0), q[127:64] != 0, q[63:0]);
	endfunction

	// LU with partial pivoting, then both substitutions; true on a zero pivot
	function automatic bit lu_solve(input int n);
		bit          sing;
		int          best;
		logic [63:0] bm;
		longint      t, l;
		sing = 0;
		for (int i = 0; i + 1 < n; i++) begin
			best = i;
			bm = umag(mat[i][i]);
			for (int j = i + 1; j < n; j++)
				if (bm < umag(mat[j][i])) begin
					bm = umag(mat[j][i]);
					best = j;
				end
			if (best != i) begin
				for (int k = 0; k < n; k++) begin
					t = mat[i][k];
					mat[i][k] = mat[best][k];
					mat[best][k] = t;
				end
				t = vec[i];
				vec[i] = vec[best];
				vec[best] = t;
			end
			if (mat[i][i] == 0)
				sing = 1;
			for (int j = i + 1; j < n; j++) begin
				l = q_div(mat[j][i], mat[i][i]);
				mat[j][i] = l;
				for (int k = i + 1; k < n; k++)
					mat[j][k] = q_sub(mat[j][k], q_mul(l, mat[i][k]));
			end
		end
		for (int i = 1; i < n; i++)
			for (int j = 0; j < i; j++)
				vec[i] = q_sub(vec[i], q_mul(mat[i][j], vec[j]));
		for (int i = n - 1; i >= 0; i--) begin
			for (int j = n - 1; j > i; j--)
				vec[i] = q_sub(vec[i], q_mul(mat[i][j], vec[j]));
			if (mat[i][i] == 0)
				sing = 1;
			vec[i] = q_div(vec[i], mat[i][i]);
		end
		return sing;
	endfunction

	task automatic take_point(input longint x, input longint y, input bit last);
		longint p;
		int     d;
		bit     sing;
		coef_t  c;
		p = longint'(ONE_Q32);
		for (int k = 0; k < NPOW; k++) begin
			psum[k] = acc_add(psum[k], p, acc_ovf);
			if (k < NDIM)
				xsum[k] = acc_add(xsum[k], (p * y + 16384) >>> 15, acc_ovf);
			p = (p * x + 16384) >>> 15;
		end
		if (!last)
			return;
		d = degree;
		for (int i = 0; i <= d; i++) begin
			for (int j = 0; j <= d; j++)
				mat[i][j] = psum[(d - i) + (d - j)];
			vec[i] = xsum[d - i];
		end
		sing = lu_solve(d + 1);
		for (int i = 0; i <= d; i++) begin
			c.coefficient  = vec[i];
			c.coeff_index  = IDX_W'(i);
			c.last_coeff   = (i == d);
			c.singular     = sing;
			c.sum_overflow = acc_ovf;
			coef_q.push_back(c);
		end
		foreach (psum[k]) psum[k] = 0;
		foreach (xsum[k]) xsum[k] = 0;
		acc_ovf = 0;
	endtask

	always @(posedge clk or negedge arst_n) begin
		coef_t c, e;
		if (!arst_n) begin
			foreach (psum[k]) psum[k] = 0;
			foreach (xsum[k]) xsum[k] = 0;
			acc_ovf = 0;
			degree = DEG_RESET;
			errors = 0;
		end else begin
			if (cfg_we)
				degree = cfg_wdata;
			if (cf.valid && cf.ready) begin
				c = '{cf.coefficient, cf.coeff_index, cf.last_coeff, cf.singular,
					cf.sum_overflow};
				if (coef_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("%0t: unexpected coefficient %h idx %0d", $realtime,
							c.coefficient, c.coeff_index);
				end else begin
					e = coef_q.pop_front();
					if (c !== e) begin
						errors++;
						if (errors <= 10)
							$display("%0t: coef exp %h/%0d/%b%b%b got %h/%0d/%b%b%b",
								$realtime, e.coefficient, e.coeff_index, e.last_coeff,
								e.singular, e.sum_overflow, c.coefficient, c.coeff_index,
								c.last_coeff, c.singular, c.sum_overflow);
					end
				end
			end
			if (pt.valid && pt.ready)
				take_point(longint'(pt.x_value), longint'(pt.y_value), pt.last_point);
		end
		pending = coef_q.size();
	end

endmodule

// ===== verif/polynomial_least_squares_fit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polynomial_least_squares_fit_tb
// Feeds data sets of (x, y) points to the fitter at several degrees and lets
// the checker predict and compare the coefficients. Both channels idle at
// random; the coefficient side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module polynomial_least_squares_fit_tb;
	import plsf_pkg::*;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [DEG_W-1:0] cfg_wdata;
	int               errors;
	int               pending;
	int               n_points;
	bit               held_off;

	plsf_point_if pt();
	plsf_coef_if  cf();

	polynomial_least_squares_fit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.point     (pt),
		.coef      (cf)
	);

	plsf_fit_checker u_chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.pt        (pt),
		.cf        (cf),
		.errors    (errors),
		.pending   (pending)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// mostly short gaps, the odd long one
	function automatic int gap_len();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(15, 60);
		return $urandom_range(0, 2);
	endfunction

	// one point transfer, then a random pause; valid stays up if no pause
	task automatic send_point(input logic [15:0] x, input logic [15:0] y, input bit last);
		int g;
		pt.valid      <= 1'b1;
		pt.x_value    <= x;
		pt.y_value    <= y;
		pt.last_point <= last;
		do @(posedge clk); while (!pt.ready);
		n_points++;
		g = (n_points % 40 < 8) ? 0 : gap_len();
		if (g > 0) begin
			pt.valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	// drop the point channel, let every coefficient out, then allow the block to settle
	task automatic wait_idle();
		pt.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic set_degree(input logic [DEG_W-1:0] d);
		wait_idle();
		cfg_we    <= 1'b1;
		cfg_wdata <= d;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	function automatic logic [15:0] pick_sample();
		case ($urandom_range(0, 5))
			0:       return 16'h7FFF;
			1:       return 16'h8000;
			2:       return 16'($signed($urandom_range(0, 511)) - 256);
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic send_set(input int len);
		for (int i = 0; i < len; i++)
			send_point(pick_sample(), pick_sample(), i == len - 1);
	endtask

	// coefficient side: bursts of ready with random holes, one long hold-off
	initial begin
		cf.ready = 1'b0;
		held_off = 0;
		@(posedge arst_n);
		forever begin
			if (!held_off && cf.valid) begin
				cf.ready <= 1'b0;
				repeat (400) @(posedge clk);
				held_off = 1;
			end
			cf.ready <= 1'b1;
			repeat ($urandom_range(1, 20)) @(posedge clk);
			if ($urandom_range(0, 2) == 0) begin
				cf.ready <= 1'b0;
				repeat ($urandom_range(1, 1 + gap_len())) @(posedge clk);
			end
		end
	end

	initial begin
		int deg;
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_wdata     = '0;
		pt.valid      = 1'b0;
		pt.x_value    = '0;
		pt.y_value    = '0;
		pt.last_point = 1'b0;
		n_points      = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// straight line through the extremes at the reset degree
		send_point(16'h0000, 16'h0000, 1'b0);
		send_point(16'h7FFF, 16'h8000, 1'b0);
		send_point(16'h8000, 16'h7FFF, 1'b1);
		// a single point at the origin leaves a zero pivot; sent at once so the
		// long hold-off above backs the block up onto the point channel
		send_point(16'h0000, 16'h1234, 1'b1);
		set_degree(3'd1);
		send_point(16'h4000, 16'hC000, 1'b0);
		send_point(16'h4000, 16'h2000, 1'b1);  // repeated x: singular
		set_degree(3'd0);
		send_point(16'hFFFF, 16'h0001, 1'b0);
		send_point(16'h0001, 16'hFFFF, 1'b1);
		set_degree(3'd7);
		for (int i = 0; i < 9; i++)
			send_point(16'(i * 7000 - 28000), pick_sample(), i == 8);
		set_degree(3'd3);
		send_set(5);

		// random sets; mostly low degrees, degrees 4 to 7 now and then
		deg = 3;
		while (n_points < 155) begin
			if ($urandom_range(0, 2) == 0) begin
				deg = ($urandom_range(0, 4) == 0) ? $urandom_range(4, 7) : $urandom_range(0, 3);
				set_degree(3'(deg));
			end
			send_set(deg + $urandom_range(1, 6));
		end
		pt.valid <= 1'b0;
		wait_idle();
		if (errors == 0)
			$display("PASS polynomial_least_squares_fit");
		else
			$display("FAIL polynomial_least_squares_fit");
		$finish;
	end

	initial begin
		#50ms;
		$display("FAIL polynomial_least_squares_fit");
		$finish;
	end

endmodule
